// File: hdl/frlm_pkg.sv
// shared types and constants of the frame rate and load monitor
package frlm_pkg;

  typedef struct packed {
    logic        func;
    logic [31:0] timestamp_ms;
    logic [31:0] render_ms;
    logic [31:0] flush_ms;
  } in_word_t;

  typedef struct packed {
    logic [9:0]  frames_per_second;
    logic [6:0]  load_percent;
    logic [31:0] avg_render_ms;
    logic [31:0] avg_flush_ms;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_DECIDE,
    S_DIV_GO,
    S_DIV_RUN,
    S_OUT
  } state_t;

  // which quotient the shared divider is working on
  typedef enum logic [1:0] {
    SEL_FPS,
    SEL_LOAD,
    SEL_REND,
    SEL_FLSH
  } div_sel_t;

  localparam logic [1:0]  CFG_PERIOD    = 2'd0;
  localparam logic [1:0]  CFG_MAX_FPS   = 2'd1;

  localparam logic [15:0] PERIOD_RESET  = 16'd1000;
  localparam logic [9:0]  MAX_FPS_RESET = 10'd60;

  localparam logic [31:0] FPS_SCALE     = 32'd1000;
  localparam logic [31:0] LOAD_SCALE    = 32'd100;
  localparam logic [6:0]  LOAD_CAP      = 7'd100;

endpackage

// File: hdl/frlm_div.sv
// restoring divider, one quotient bit per cycle
module frlm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quot
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] q;
  logic [31:0] rem;
  logic [33:0] trial;
  logic        ge;

  always_comb begin
    trial = {1'b0, rem, q[31]} - {2'b00, den};
    ge    = ~trial[33];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        q    <= num;
        rem  <= '0;
      end else if (busy) begin
        rem <= ge ? trial[31:0] : {rem[30:0], q[31]};
        q   <= {q[30:0], ge};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q;

endmodule

// File: hdl/frame_rate_load_monitor_core.sv
// top level of the frame rate and load monitor
// Each word is either a frame refresh (func 0) or a work record (func 1). The counters, the
// render and flush sums and the window time pass through bit-serial adders, one bit per cycle
// LSB first, so every word takes an accept step, 32 serial bit steps and a decide step.
// A refresh that closes the window then runs the shared 32-step divider for the frame rate,
// the load and, when work was recorded, the two averages, one quotient after another, and
// the report may then wait for the output register to drain.
// The finished report sits in an output register, so a waiting report does not block the
// serial update of later words once the block has moved on. Configuration writes are taken
// at any time, but belong in idle periods.
module frame_rate_load_monitor_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  frlm_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output frlm_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  frlm_pkg::state_t   state, state_next;
  frlm_pkg::div_sel_t div_sel;

  logic [15:0] period;
  logic [9:0]  max_fps;

  logic        started;
  logic [31:0] wstart, rcnt, wcnt, rsum, fsum;
  logic [31:0] elapsed;
  logic [31:0] ts_sr, r_sr, f_sr;
  logic        func_q;
  logic [4:0]  bit_cnt;
  logic        c_r, c_f, c_w, c_rc, b_el, b_cmp, el_nz, rc_nz;

  logic [31:0] sum_rf, prod_fps;
  logic [9:0]  res_fps;
  logic [6:0]  res_load;
  logic [31:0] res_rend, res_flsh;

  logic        in_accept, out_free, report, last_div;
  logic        div_start, div_done;
  logic [31:0] div_num, div_den, div_quot;

  // serial bit signals
  logic t_b, ws_b, e_b, p_b, rs_b, fs_b, wc_b, rc_b;
  logic b_el_n, b_cmp_n, c_r_n, c_f_n;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign report    = !func_q && el_nz && rc_nz && !b_cmp;
  assign last_div  = (div_sel == frlm_pkg::SEL_FLSH) ||
                     (div_sel == frlm_pkg::SEL_LOAD && wcnt == 32'd0);

  always_comb begin
    t_b     = ts_sr[0];
    ws_b    = started ? wstart[0] : t_b;
    e_b     = t_b ^ ws_b ^ b_el;
    b_el_n  = (~t_b & ws_b) | (~(t_b ^ ws_b) & b_el);
    p_b     = bit_cnt[4] ? 1'b0 : period[bit_cnt[3:0]];
    b_cmp_n = (~e_b & p_b) | (~(e_b ^ p_b) & b_cmp);
    rs_b    = rsum[0] ^ r_sr[0] ^ c_r;
    c_r_n   = (rsum[0] & r_sr[0]) | (rsum[0] & c_r) | (r_sr[0] & c_r);
    fs_b    = fsum[0] ^ f_sr[0] ^ c_f;
    c_f_n   = (fsum[0] & f_sr[0]) | (fsum[0] & c_f) | (f_sr[0] & c_f);
    wc_b    = wcnt[0] ^ c_w;
    rc_b    = rcnt[0] ^ c_rc;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      frlm_pkg::S_IDLE:    if (in_accept) state_next = frlm_pkg::S_SHIFT;
      frlm_pkg::S_SHIFT:   if (bit_cnt == 5'd31) state_next = frlm_pkg::S_DECIDE;
      frlm_pkg::S_DECIDE:  state_next = report ? frlm_pkg::S_DIV_GO : frlm_pkg::S_IDLE;
      frlm_pkg::S_DIV_GO:  state_next = frlm_pkg::S_DIV_RUN;
      frlm_pkg::S_DIV_RUN: begin
        if (div_done) state_next = last_div ? frlm_pkg::S_OUT : frlm_pkg::S_DIV_GO;
      end
      frlm_pkg::S_OUT:     if (out_free) state_next = frlm_pkg::S_IDLE;
      default:             state_next = frlm_pkg::S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    unique case (state)
      frlm_pkg::S_IDLE:   in_stall  = 1'b0;
      frlm_pkg::S_DIV_GO: div_start = 1'b1;
      default: ;
    endcase
  end

  // rounded numerator and divisor for the quotient in hand
  always_comb begin
    unique case (div_sel)
      frlm_pkg::SEL_FPS: begin
        div_num = prod_fps + {1'b0, elapsed[31:1]};
        div_den = elapsed;
      end
      frlm_pkg::SEL_LOAD: begin
        div_num = 32'(sum_rf * frlm_pkg::LOAD_SCALE) + {1'b0, elapsed[31:1]};
        div_den = elapsed;
      end
      frlm_pkg::SEL_REND: begin
        div_num = rsum + {1'b0, wcnt[31:1]};
        div_den = wcnt;
      end
      frlm_pkg::SEL_FLSH: begin
        div_num = fsum + {1'b0, wcnt[31:1]};
        div_den = wcnt;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  frlm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= frlm_pkg::S_IDLE;
      period    <= frlm_pkg::PERIOD_RESET;
      max_fps   <= frlm_pkg::MAX_FPS_RESET;
      started   <= 1'b0;
      wstart    <= '0;
      rcnt      <= '0;
      wcnt      <= '0;
      rsum      <= '0;
      fsum      <= '0;
      out_valid <= 1'b0;
      div_sel   <= frlm_pkg::SEL_FPS;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          frlm_pkg::CFG_PERIOD:  period  <= cfg_data;
          frlm_pkg::CFG_MAX_FPS: max_fps <= cfg_data[9:0];
          default: ;
        endcase
      end

      // a new report in the same cycle keeps the output word valid
      if (out_valid && !out_stall && state != frlm_pkg::S_OUT) out_valid <= 1'b0;

      unique case (state)
        frlm_pkg::S_IDLE: begin
          if (in_accept) begin
            func_q  <= in_data.func;
            ts_sr   <= in_data.timestamp_ms;
            r_sr    <= in_data.func ? in_data.render_ms : 32'd0;
            f_sr    <= in_data.func ? in_data.flush_ms : 32'd0;
            c_r     <= 1'b0;
            c_f     <= 1'b0;
            c_w     <= in_data.func;
            c_rc    <= ~in_data.func;
            b_el    <= 1'b0;
            b_cmp   <= 1'b0;
            el_nz   <= 1'b0;
            rc_nz   <= 1'b0;
            bit_cnt <= '0;
          end
        end
        frlm_pkg::S_SHIFT: begin
          // timestamp, sums and counters rotate, so each is back in place after 32 steps; r_sr and f_sr empty
          ts_sr   <= {t_b, ts_sr[31:1]};
          wstart  <= {ws_b, wstart[31:1]};
          elapsed <= {e_b, elapsed[31:1]};
          r_sr    <= {1'b0, r_sr[31:1]};
          f_sr    <= {1'b0, f_sr[31:1]};
          rsum    <= {rs_b, rsum[31:1]};
          fsum    <= {fs_b, fsum[31:1]};
          wcnt    <= {wc_b, wcnt[31:1]};
          rcnt    <= {rc_b, rcnt[31:1]};
          c_r     <= c_r_n;
          c_f     <= c_f_n;
          c_w     <= wcnt[0] & c_w;
          c_rc    <= rcnt[0] & c_rc;
          b_el    <= b_el_n;
          b_cmp   <= b_cmp_n;
          el_nz   <= el_nz | e_b;
          rc_nz   <= rc_nz | rc_b;
          bit_cnt <= bit_cnt + 5'd1;
        end
        frlm_pkg::S_DECIDE: begin
          started  <= 1'b1;
          sum_rf   <= rsum + fsum;
          prod_fps <= 32'(rcnt * frlm_pkg::FPS_SCALE);
          res_rend <= '0;
          res_flsh <= '0;
          div_sel  <= frlm_pkg::SEL_FPS;
        end
        frlm_pkg::S_DIV_RUN: begin
          if (div_done) begin
            unique case (div_sel)
              frlm_pkg::SEL_FPS:
                res_fps  <= (div_quot > {22'd0, max_fps}) ? max_fps : div_quot[9:0];
              frlm_pkg::SEL_LOAD:
                res_load <= (div_quot > {25'd0, frlm_pkg::LOAD_CAP}) ?
                            frlm_pkg::LOAD_CAP : div_quot[6:0];
              frlm_pkg::SEL_REND: res_rend <= div_quot;
              frlm_pkg::SEL_FLSH: res_flsh <= div_quot;
              default: ;
            endcase
            div_sel <= frlm_pkg::div_sel_t'(div_sel + 2'd1);
          end
        end
        frlm_pkg::S_OUT: begin
          if (out_free) begin
            out_valid                  <= 1'b1;
            out_data.frames_per_second <= res_fps;
            out_data.load_percent      <= res_load;
            out_data.avg_render_ms     <= res_rend;
            out_data.avg_flush_ms      <= res_flsh;
            // window restarts at this refresh
            wstart <= ts_sr;
            rcnt   <= '0;
            wcnt   <= '0;
            rsum   <= '0;
            fsum   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
